@@ rtl/core/rct_pkg.sv @@
package rct_pkg;

   localparam int NUM_CHAN  = 4;
   localparam int PIX_W     = 8;
   localparam int COEF_W    = 16;
   localparam int CSR_IDX_W = 4;

   typedef logic [PIX_W-1:0]         pixel_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef pixel_type [NUM_CHAN-1:0] pixel_vec_type;
   typedef coef_type [NUM_CHAN-1:0]  coef_vec_type;

   // channel slots in a pixel vector
   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;
   localparam int CH_ALPHA = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RED_MUL   = 4'd0,
      CSR_GREEN_MUL = 4'd1,
      CSR_BLUE_MUL  = 4'd2,
      CSR_ALPHA_MUL = 4'd3,
      CSR_RED_OFS   = 4'd4,
      CSR_GREEN_OFS = 4'd5,
      CSR_BLUE_OFS  = 4'd6,
      CSR_ALPHA_OFS = 4'd7
   } csr_index_type;

   localparam coef_type GAIN_UNITY = 16'sd256;   // 1.0 in 8.8
   localparam coef_type OFS_ZERO   = 16'sd0;

endpackage

@@ rtl/core/rct_channel.sv @@
module rct_channel (
   input  rct_pkg::pixel_type pix,
   input  rct_pkg::coef_type  gain,
   input  rct_pkg::coef_type  offset,
   output rct_pkg::pixel_type result
);

   logic signed [24:0] prod;
   logic signed [15:0] scaled;
   logic signed [16:0] sum;

   // 16b signed x 9b (zero-extended pixel) fits in 24 bits signed
   assign prod   = gain * $signed({1'b0, pix});
   // arithmetic shift by 8: floor rounding
   assign scaled = prod[23:8];
   assign sum    = {scaled[15], scaled} + {offset[15], offset};

   always_comb begin
      priority if (sum[16]) begin
         result = '0;
      end else if (sum[15:8] != '0) begin
         result = '1;
      end else begin
         result = sum[7:0];
      end
   end

endmodule

@@ rtl/core/rgba_color_transform.sv @@
// A request accepted into the input register passes through multiply/shift/add/clamp
//   into the result register, which drives rsp_valid.
// Throughput: one pixel per clock while rsp_stall is low; the two pipeline registers
//   let a new request in while a finished result still waits behind rsp_stall.
// Reset (synchronous, active high): pipeline emptied, gains set to 256
//   (unity in 8.8) and offsets to 0, i.e. a pass-through transform.
module rgba_color_transform (
   input  logic                                clock,
   input  logic                                reset,
   // pixel requests
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rct_pkg::PIX_W-1:0]           req_red_in,
   input  logic [rct_pkg::PIX_W-1:0]           req_green_in,
   input  logic [rct_pkg::PIX_W-1:0]           req_blue_in,
   input  logic [rct_pkg::PIX_W-1:0]           req_alpha_in,
   // transformed pixels
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rct_pkg::PIX_W-1:0]           rsp_red_out,
   output logic [rct_pkg::PIX_W-1:0]           rsp_green_out,
   output logic [rct_pkg::PIX_W-1:0]           rsp_blue_out,
   output logic [rct_pkg::PIX_W-1:0]           rsp_alpha_out,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rct_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rct_pkg::COEF_W-1:0]          csr_wdata
);

   // ------------------------------------------------------------------
   // Control registers. Writes are always taken; indexes past the
   // alpha offset are dropped.
   // ------------------------------------------------------------------
   rct_pkg::coef_vec_type gain_ff;
   rct_pkg::coef_vec_type offset_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rct_pkg::NUM_CHAN; i++) begin
            gain_ff[i]   <= rct_pkg::GAIN_UNITY;
            offset_ff[i] <= rct_pkg::OFS_ZERO;
         end
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rct_pkg::CSR_RED_MUL:   gain_ff[rct_pkg::CH_RED]     <= csr_wdata;
            rct_pkg::CSR_GREEN_MUL: gain_ff[rct_pkg::CH_GREEN]   <= csr_wdata;
            rct_pkg::CSR_BLUE_MUL:  gain_ff[rct_pkg::CH_BLUE]    <= csr_wdata;
            rct_pkg::CSR_ALPHA_MUL: gain_ff[rct_pkg::CH_ALPHA]   <= csr_wdata;
            rct_pkg::CSR_RED_OFS:   offset_ff[rct_pkg::CH_RED]   <= csr_wdata;
            rct_pkg::CSR_GREEN_OFS: offset_ff[rct_pkg::CH_GREEN] <= csr_wdata;
            rct_pkg::CSR_BLUE_OFS:  offset_ff[rct_pkg::CH_BLUE]  <= csr_wdata;
            rct_pkg::CSR_ALPHA_OFS: offset_ff[rct_pkg::CH_ALPHA] <= csr_wdata;
            default: ;  // unmapped index, ignore
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Two-stage pipeline: s1 holds the accepted request, s2 the result.
   // s2 takes a new value whenever it is empty or being drained; s1
   // moves on in the same cycle, so a full pipe streams 1/clk while rsp_stall is low.
   // ------------------------------------------------------------------
   logic                   s1_valid_ff, s1_valid_in;
   rct_pkg::pixel_vec_type s1_pix_ff;
   logic                   s2_valid_ff, s2_valid_in;
   rct_pkg::pixel_vec_type s2_pix_ff;
   rct_pkg::pixel_vec_type s2_pix_in;
   logic                   s2_load;
   logic                   req_take;

   assign s2_load   = !s2_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s2_load;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in = req_stall ? s1_valid_ff : req_valid;
   assign s2_valid_in = s2_load ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_pix_ff[rct_pkg::CH_RED]   <= req_red_in;
         s1_pix_ff[rct_pkg::CH_GREEN] <= req_green_in;
         s1_pix_ff[rct_pkg::CH_BLUE]  <= req_blue_in;
         s1_pix_ff[rct_pkg::CH_ALPHA] <= req_alpha_in;
      end
      if (s2_load && s1_valid_ff) begin
         s2_pix_ff <= s2_pix_in;
      end
   end

   // one multiply/shift/offset/clamp lane per channel
   for (genvar ch = 0; ch < rct_pkg::NUM_CHAN; ch++) begin : g_lane
      rct_channel u_chan (
         .pix    (s1_pix_ff[ch]),
         .gain   (gain_ff[ch]),
         .offset (offset_ff[ch]),
         .result (s2_pix_in[ch])
      );
   end

   assign rsp_valid     = s2_valid_ff;
   assign rsp_red_out   = s2_pix_ff[rct_pkg::CH_RED];
   assign rsp_green_out = s2_pix_ff[rct_pkg::CH_GREEN];
   assign rsp_blue_out  = s2_pix_ff[rct_pkg::CH_BLUE];
   assign rsp_alpha_out = s2_pix_ff[rct_pkg::CH_ALPHA];

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   // pipe comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !s2_valid_ff))
      else $error("pipeline not empty after reset");

   // back-pressure only when a request is actually parked in s1
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && rsp_stall))
      else $error("req_stall without a blocked s1");

   // a request leaving s1 always lands in s2
   a_s1_to_s2: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_load) |=> s2_valid_ff)
      else $error("request lost between s1 and s2");

   // red gain write takes effect on the next cycle
   a_csr_red_gain: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && csr_index == rct_pkg::CSR_RED_MUL)
      |=> (gain_ff[rct_pkg::CH_RED] == $signed($past(csr_wdata))))
      else $error("red gain write not applied");

endmodule
